FILE: design/asa_pkg.sv
// ----------------------------------------------------------------------------
// asa_pkg: shared definitions of the aligned span allocator
// Request and result payload types, request and status codes, configuration
// register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package asa_pkg;

  // Default sizing of the span table and address space
  localparam int DEF_MAX_SPANS = 16;
  localparam int DEF_ADDR_BITS = 32;

  // Request codes
  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_ADD_AT   = 2'd1;
  localparam logic [1:0] REQ_PROBE_AT = 2'd2;
  localparam logic [1:0] REQ_PLACE    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COLLIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOROOM  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEADER_SIZE   = 2'd0;
  localparam logic [1:0] CFG_ALIGN_LOG2    = 2'd1;
  localparam logic [1:0] CFG_ROUND_LENGTHS = 2'd2;

  // Configuration reset values
  localparam logic [31:0] HEADER_SIZE_RESET   = 32'd1024;
  localparam logic [4:0]  ALIGN_LOG2_RESET    = 5'd12;
  localparam logic        ROUND_LENGTHS_RESET = 1'b0;

  // Request payload
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_start;
    logic [31:0] req_length;
  } asa_req_t;

  // Result payload
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] placed_start;
    logic [4:0]  span_count;
  } asa_rsp_t;

endpackage

`default_nettype wire

FILE: design/aligned_span_allocator_unit.sv
// ----------------------------------------------------------------------------
// aligned_span_allocator_unit: first-fit aligned span allocator
// Span table with clear, exact add, probe and aligned first-fit placement.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the sequencer
// is idle, and a finished result may wait in the output register while the
// next request is taken. A clear writes the header span as entry zero; an
// add or place on a full table gets a full status with no table walk. A
// probe or add walks the span table through a single registered read port,
// forming each span's end address and then running one shared containment
// test four times per span. A place scans candidate starts, each aligned up
// and walked the same way, and answers no room once a candidate passes the
// top address; a collision moves the candidate past the farthest colliding
// span, rounded up to the alignment. A final state moves the result into the
// output register and waits while an earlier result still sits there untaken.
// The table needs no clearing pass after reset.
`default_nettype none

module aligned_span_allocator_unit #(
  parameter int MAX_SPANS = asa_pkg::DEF_MAX_SPANS,
  parameter int ADDR_BITS = asa_pkg::DEF_ADDR_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire asa_pkg::asa_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output asa_pkg::asa_rsp_t       out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  import asa_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam int IDX_W = $clog2(MAX_SPANS);
  localparam logic [AW-1:0] AMASK = {AW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_CAL, S_CU, S_CD, S_SPE, S_T0, S_T1, S_T2, S_T3, S_EVAL, S_FIN
  } state_t;

  // Round up to the alignment without wrap
  function automatic logic [AW:0] align_up(input logic [AW:0] x, input logic [AW:0] lm);
    return (x + lm) & ~lm;
  endfunction

  state_t           state_r;
  logic [31:0]      header_r;
  logic [4:0]       align_r;
  logic             round_r;
  logic [1:0]       type_r;
  logic [AW-1:0]    start_r;
  logic [AW-1:0]    len_raw_r;
  logic [AW-1:0]    n_r;
  logic [AW:0]      x_r;
  logic [AW:0]      c_r;
  logic [AW-1:0]    u_r;
  logic [AW-1:0]    cend_r;
  logic [AW-1:0]    mn_r;
  logic [AW+1:0]    d_r;
  logic [AW-1:0]    e_r;
  logic [AW-1:0]    last_r;
  logic [AW:0]      hi_r;
  logic             hit_r;
  logic [CNT_W-1:0] k_r;
  logic [CNT_W-1:0] count_r;
  logic [1:0]       res_status_r;
  logic [AW-1:0]    res_placed_r;
  logic             out_valid_r;
  asa_rsp_t         out_data_r;

  logic [4:0]       alk;
  logic [AW:0]      lo_mask;
  logic [AW-1:0]    c_a;
  logic [AW:0]      len_up;
  logic [AW-1:0]    eff_len;
  logic [AW-1:0]    rd_start;
  logic [AW-1:0]    rd_len;
  logic [AW-1:0]    t_base;
  logic [AW-1:0]    t_bend;
  logic [AW-1:0]    t_point;
  logic [AW:0]      t_cand;
  logic             t_hit;
  logic [AW:0]      hi_nxt;
  logic [AW+1:0]    t1_sum;
  logic [AW-1:0]    t1_cap;
  logic             is_alloc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [AW-1:0]    wr_start;
  logic [AW-1:0]    wr_len;

  // Effective alignment, capped to the top address bit
  assign alk     = (align_r > 5'(AW - 1)) ? 5'(AW - 1) : align_r;
  assign lo_mask = ~({(AW + 1){1'b1}} << alk);
  assign c_a     = c_r[AW-1:0];
  // Rounded length wraps to the address width
  assign len_up  = align_up({1'b0, len_raw_r}, lo_mask);
  assign eff_len = round_r ? len_up[AW-1:0] : len_raw_r;
  assign is_alloc = (type_r == REQ_ADD_AT) || (type_r == REQ_PLACE);

  // Candidate bound for the end-address test, capped at the top address
  assign t1_sum = {2'b00, last_r} + d_r;
  assign t1_cap = (t1_sum > {2'b00, AMASK}) ? AMASK : t1_sum[AW-1:0];

  // Route operands into the shared containment test per phase
  always_comb begin
    t_base  = '0;
    t_bend  = '0;
    t_point = '0;
    t_cand  = '0;
    unique case (state_r)
      S_T0: begin
        t_base  = rd_start;
        t_bend  = e_r;
        t_point = c_a;
        t_cand  = {1'b0, e_r - AW'(1)};
      end
      S_T1: begin
        t_base  = rd_start;
        t_bend  = e_r;
        t_point = u_r;
        t_cand  = {1'b0, t1_cap};
      end
      S_T2: begin
        t_base  = c_a;
        t_bend  = cend_r;
        t_point = rd_start;
        t_cand  = {1'b0, (rd_start < mn_r) ? rd_start : mn_r};
      end
      S_T3: begin
        t_base  = c_a;
        t_bend  = cend_r;
        t_point = last_r;
        t_cand  = {1'b0, (last_r < mn_r) ? last_r : mn_r};
      end
      default: begin
      end
    endcase
  end

  // Shared test: point lies in [base, bend), track the farthest bound
  assign t_hit  = (t_point >= t_base) && (t_bend > t_point);
  assign hi_nxt = (t_hit && (t_cand > hi_r)) ? t_cand : hi_r;

  // Table writes: header on clear, new span on a successful store
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = count_r[IDX_W-1:0];
    wr_start = c_a;
    wr_len   = n_r;
    if (state_r == S_LEN && type_r == REQ_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = '0;
      wr_start = '0;
      wr_len   = header_r[AW-1:0];
    end else if (state_r == S_EVAL && !hit_r && type_r != REQ_PROBE_AT) begin
      wr_en = 1'b1;
    end
  end

  asa_span_mem #(
    .MAX_SPANS (MAX_SPANS),
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_start (wr_start),
    .wr_len   (wr_len),
    .rd_addr  (k_r[IDX_W-1:0]),
    .rd_start (rd_start),
    .rd_len   (rd_len)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_SIZE_RESET;
      align_r  <= ALIGN_LOG2_RESET;
      round_r  <= ROUND_LENGTHS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEADER_SIZE:   header_r <= cfg_data;
        CFG_ALIGN_LOG2:    align_r  <= cfg_data[4:0];
        CFG_ROUND_LENGTHS: round_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer with result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished result, or drop the one just transferred
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            type_r    <= in_data.req_type;
            start_r   <= in_data.req_start[AW-1:0];
            len_raw_r <= in_data.req_length[AW-1:0];
            state_r   <= S_LEN;
          end
        end
        S_LEN: begin
          n_r <= eff_len;
          x_r <= {1'b0, start_r};
          if (type_r == REQ_CLEAR) begin
            count_r      <= CNT_W'(1);
            res_status_r <= ST_OK;
            res_placed_r <= '0;
            state_r      <= S_FIN;
          end else if (is_alloc && count_r == CNT_W'(MAX_SPANS)) begin
            res_status_r <= ST_FULL;
            res_placed_r <= start_r;
            state_r      <= S_FIN;
          end else begin
            state_r <= S_CAL;
          end
        end
        S_CAL: begin
          c_r     <= (type_r == REQ_PLACE) ? align_up(x_r, lo_mask) : x_r;
          k_r     <= '0;
          state_r <= S_CU;
        end
        S_CU: begin
          if (c_r[AW]) begin
            res_status_r <= ST_NOROOM;
            res_placed_r <= '0;
            state_r      <= S_FIN;
          end else begin
            u_r     <= c_a + n_r - AW'(1);
            cend_r  <= c_a + n_r;
            mn_r    <= AMASK - n_r;
            hi_r    <= c_r;
            hit_r   <= 1'b0;
            state_r <= S_CD;
          end
        end
        S_CD: begin
          d_r     <= {2'b00, c_a} - {2'b00, u_r};
          state_r <= (count_r == '0) ? S_EVAL : S_SPE;
        end
        S_SPE: begin
          e_r     <= rd_start + rd_len;
          state_r <= S_T0;
        end
        S_T0: begin
          last_r  <= e_r - AW'(1);
          hi_r    <= hi_nxt;
          hit_r   <= hit_r | t_hit;
          state_r <= S_T1;
        end
        S_T1: begin
          hi_r    <= hi_nxt;
          hit_r   <= hit_r | t_hit;
          state_r <= S_T2;
        end
        S_T2: begin
          // advance the read address early so the next span is ready
          hi_r    <= hi_nxt;
          hit_r   <= hit_r | t_hit;
          k_r     <= k_r + CNT_W'(1);
          state_r <= S_T3;
        end
        S_T3: begin
          hi_r    <= hi_nxt;
          hit_r   <= hit_r | t_hit;
          state_r <= (k_r == count_r) ? S_EVAL : S_SPE;
        end
        S_EVAL: begin
          if (!hit_r) begin
            if (type_r != REQ_PROBE_AT) begin
              count_r <= count_r + CNT_W'(1);
            end
            res_status_r <= ST_OK;
            res_placed_r <= c_a;
            state_r      <= S_FIN;
          end else if (type_r == REQ_PLACE) begin
            x_r     <= hi_r + (AW + 1)'(1);
            state_r <= S_CAL;
          end else begin
            res_status_r <= ST_COLLIDE;
            res_placed_r <= start_r;
            state_r      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.status       <= res_status_r;
            out_data_r.placed_start <= 32'(res_placed_r);
            out_data_r.span_count   <= 5'(count_r);
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Table never grows past its depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SPANS))
    else $error("span count exceeds table depth");

  // A full answer reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.span_count == 5'(MAX_SPANS)))
    else $error("table full reported with free entries");

  // A failed placement reports start zero
  a_noroom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_NOROOM) |-> (out_data.placed_start == 32'd0))
    else $error("no room result with nonzero start");

  // An accepted request keeps the sequencer busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule

`default_nettype wire

FILE: design/asa_span_mem.sv
// ----------------------------------------------------------------------------
// asa_span_mem: span table storage
// One write port and one registered read port holding start and length of
// every stored span.
// ----------------------------------------------------------------------------
`default_nettype none

module asa_span_mem #(
  parameter int MAX_SPANS = asa_pkg::DEF_MAX_SPANS,
  parameter int ADDR_BITS = asa_pkg::DEF_ADDR_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_SPANS)-1:0] wr_addr,
  input  wire logic [ADDR_BITS-1:0]         wr_start,
  input  wire logic [ADDR_BITS-1:0]         wr_len,
  input  wire logic [$clog2(MAX_SPANS)-1:0] rd_addr,
  output logic      [ADDR_BITS-1:0]         rd_start,
  output logic      [ADDR_BITS-1:0]         rd_len
);

  import asa_pkg::*;

  logic [2*ADDR_BITS-1:0] mem_r [MAX_SPANS];
  logic [2*ADDR_BITS-1:0] rd_r;

  // Write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_start, wr_len};
    end
    rd_r <= mem_r[rd_addr];
  end

  assign rd_start = rd_r[2*ADDR_BITS-1:ADDR_BITS];
  assign rd_len   = rd_r[ADDR_BITS-1:0];

endmodule

`default_nettype wire
